@@ src/wsce_pkg.sv @@
// Shared types and constants for the weighted soft cross-entropy loss block.
package wsce_pkg;

    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [15:0] SCALE_RST = 16'd256;
    localparam logic [14:0] EPS_RST   = 15'd66;

    localparam logic [1:0] CFG_SCALE = 2'd0;
    localparam logic [1:0] CFG_EPS   = 2'd1;
    localparam logic [1:0] CFG_MODE  = 2'd2;

    typedef struct packed {
        logic        go;
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

    typedef struct packed {
        logic        go;
        logic [63:0] a;
        logic [63:0] b;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
        logic [63:0] r;
    } t_div_rsp;

endpackage

@@ src/wsce_mul.sv @@
// Registered 32x32 unsigned multiplier with a one-cycle done pulse.
module wsce_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsce_pkg::t_mul_req i_req,
    output wsce_pkg::t_mul_rsp o_rsp
);

    logic        r_done;
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.go;
        end
        if (i_req.go) begin
            r_p <= 64'(i_req.a) * 64'(i_req.b);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

@@ src/wsce_div.sv @@
// Restoring 64/64 unsigned divider, one quotient bit per cycle.
module wsce_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsce_pkg::t_div_req i_req,
    output wsce_pkg::t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [64:0] r_rem;
    logic [63:0] r_q;

    logic [64:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem[63:0], r_a[63]};
    assign fits   = (rem_sh >= {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                if (i_req.b == 64'd0) begin
                    // zero divisor reads as a zero quotient
                    r_q    <= 64'd0;
                    r_rem  <= 65'd0;
                    r_done <= 1'b1;
                end else begin
                    r_a    <= i_req.a;
                    r_b    <= i_req.b;
                    r_rem  <= 65'd0;
                    r_q    <= 64'd0;
                    r_cnt  <= 6'd63;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= fits ? (rem_sh - {1'b0, r_b}) : rem_sh;
                r_q   <= {r_q[62:0], fits};
                r_a   <= {r_a[62:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
    assign o_rsp.r    = r_rem[63:0];

endmodule

@@ src/weighted_soft_cross_entropy_loss_top.sv @@
// Top level: sequencer, class buffers and accumulators around the shared units.
//
// Class-weighted soft-target cross-entropy loss over a stream of voxels.
// Input channel s_axis: one class element per transfer, classes innermost;
// tlast marks the last element of the data set, tuser the last class of a
// voxel. Output channel m_axis: one result per data set.
// Configuration: i_cfg_wr_en/i_cfg_index/i_cfg_wdata write scale, clip
// epsilon and weighting mode; write only while the block is idle.
// Throughput: one item at a time. All multiplies and divisions go through
// one 64/64 divider and one 32x32 multiplier. Each item costs a scaling
// multiply and the -ln p series: 12 divisions and 13 multiplies. Closing
// a voxel of n classes adds a max pass over its classes, the exp series
// (13 divisions per class) and one division per class for the softmax.
// The end of a set adds one or two divisions.
// s_axis_tready is high only while the sequencer is idle.
// Reset clears the set sums, counts, class position and output valid;
// the class buffers hold junk until written.
// A result waits in the output register while the receiver stalls; the
// next set's items are still taken, and only a second result waits for it.
module weighted_soft_cross_entropy_loss_top #(
    parameter int MAX_CLASSES = 8,
    parameter int COUNT_BITS  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // target_value[15:0], predicted_prob[31:16]
    input  logic        s_axis_tlast,   // set_last
    input  logic        s_axis_tuser,   // class_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // loss_value[31:0], free_voxels[55:32],
                                        // occupied_voxels[79:56]
    output logic        m_axis_tuser,   // overflow_flag
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    localparam int PW    = $clog2(MAX_CLASSES);
    localparam int NW    = $clog2(MAX_CLASSES + 1);
    localparam int EW    = COUNT_BITS + 3;
    localparam int TOT_W = 33 + NW;
    localparam int ACC_W = 41 + NW;

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_SCALE, S_LN_Z, S_LN_Z2, S_LN_ADD, S_LN_NEXT, S_LN_FIN,
        S_MAX, S_EXP_START, S_EXP_K, S_EXP_A, S_EXP_T, S_G_START, S_G_Q, S_G_ACC,
        S_ACCUM, S_RES, S_RQ1, S_RQ2, S_RPLAIN, S_OUT
    } t_state;

    t_state r_state;
    t_state r_ret;

    logic [15:0] r_scale;
    logic [14:0] r_eps;
    logic        r_mode;

    wsce_pkg::t_mul_req r_mul_req;
    wsce_pkg::t_mul_rsp mul_rsp;
    wsce_pkg::t_div_req r_div_req;
    wsce_pkg::t_div_rsp div_rsp;

    logic [23:0] tbuf [MAX_CLASSES];
    logic [23:0] lbuf [MAX_CLASSES];
    logic [32:0] ebuf [MAX_CLASSES];

    logic [16:0]      r_pc;
    logic             r_cl;
    logic             r_sl;
    logic [PW-1:0]    r_pos;
    logic [NW-1:0]    r_ncls;
    logic [NW-1:0]    r_c;
    logic [4:0]       r_n;
    logic [31:0]      r_term;
    logic [31:0]      r_z2;
    logic [32:0]      r_sum;
    logic [63:0]      r_s;
    logic [31:0]      r_r;
    logic [8:0]       r_k;
    logic [23:0]      r_mx;
    logic [TOT_W-1:0] r_total;
    logic [ACC_W-1:0] r_acc;
    logic [16:0]      r_best_g;
    logic             r_best_zero;
    logic [47:0]      r_fsum;
    logic [47:0]      r_osum;
    logic [COUNT_BITS-1:0] r_nf;
    logic [COUNT_BITS-1:0] r_no;
    logic [EW-1:0]    r_ec;
    logic [31:0]      r_q1;
    logic [31:0]      r_loss;

    logic        r_mv;
    logic [31:0] r_m_loss;
    logic [23:0] r_m_free;
    logic [23:0] r_m_occ;
    logic        r_m_ovf;

    logic [PW-1:0] c_idx;
    logic [16:0]   p_lo;
    logic [16:0]   p_hi;
    logic [16:0]   in_p;
    logic [16:0]   pc;
    logic [4:0]    lg_m;
    logic [63:0]   ln_y;
    logic [33:0]   lny;
    logic [23:0]   neg_ln;
    logic [23:0]   mx_new;
    logic [63:0]   s_next;
    logic [32:0]   e_val;
    logic [16:0]   g_val;
    logic [48:0]   v_sum;
    logic [48:0]   fsum_add;
    logic [48:0]   osum_add;
    logic [33:0]   loss_w;
    logic          ovf;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    wsce_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_mul_req),
        .o_rsp  (mul_rsp)
    );

    wsce_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_div_req),
        .o_rsp  (div_rsp)
    );

    assign c_idx = r_c[PW-1:0];
    assign in_p  = {1'b0, s_axis_tdata[31:16]};
    assign p_lo  = (r_eps == 15'd0) ? 17'd1 : {2'b0, r_eps};
    assign p_hi  = 17'h1_0000 - {2'b0, r_eps};
    assign pc    = (in_p < p_lo) ? p_lo : ((in_p > p_hi) ? p_hi : in_p);

    always_comb begin
        lg_m = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (r_pc[i]) begin
                lg_m = 5'(i);
            end
        end
    end

    assign ln_y   = 64'(r_pc) << (6'd32 - {1'b0, lg_m});
    assign lny    = {r_sum, 1'b0};
    assign neg_ln = (64'(lny) >= mul_rsp.p) ? 24'd0 : 24'((mul_rsp.p - 64'(lny)) >> 16);
    assign mx_new = (tbuf[c_idx] > r_mx) ? tbuf[c_idx] : r_mx;

    // odd series terms subtract
    assign s_next = r_n[0] ? (r_s - div_rsp.q) : (r_s + div_rsp.q);
    assign e_val  = (r_k >= 9'd40) ? 33'd0 : 33'(s_next >> r_k);

    assign g_val = (div_rsp.q < 64'(r_eps)) ? {2'b0, r_eps}
                 : ((div_rsp.q > 64'(p_hi)) ? p_hi : div_rsp.q[16:0]);

    assign v_sum    = 49'(r_acc >> 16);
    assign fsum_add = {1'b0, r_fsum} + v_sum;
    assign osum_add = {1'b0, r_osum} + v_sum;
    assign loss_w   = {1'b0, r_q1, 1'b0} + {2'b0, sat32(div_rsp.q)};

    assign ovf = (r_fsum == wsce_pkg::SUM_MAX) || (r_osum == wsce_pkg::SUM_MAX)
              || (r_nf == '1) || (r_no == '1) || (r_ec == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= wsce_pkg::SCALE_RST;
            r_eps   <= wsce_pkg::EPS_RST;
            r_mode  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                wsce_pkg::CFG_SCALE: r_scale <= i_cfg_wdata;
                wsce_pkg::CFG_EPS:   r_eps   <= i_cfg_wdata[14:0];
                wsce_pkg::CFG_MODE:  r_mode  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_mul_req.go <= 1'b0;
            r_div_req.go <= 1'b0;
            r_pos        <= '0;
            r_fsum       <= '0;
            r_osum       <= '0;
            r_nf         <= '0;
            r_no         <= '0;
            r_ec         <= '0;
            r_mv         <= 1'b0;
        end else begin
            r_mul_req.go <= 1'b0;
            r_div_req.go <= 1'b0;
            if (r_mv && m_axis_tready) begin
                r_mv <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pc <= pc;
                        r_cl <= s_axis_tuser;
                        r_sl <= s_axis_tlast;
                        if (r_ec != '1) begin
                            r_ec <= r_ec + 1'b1;
                        end
                        r_mul_req <= '{go: 1'b1, a: 32'(s_axis_tdata[15:0]),
                                       b: 32'(r_scale)};
                        r_ret   <= S_SCALE;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (mul_rsp.done || div_rsp.done) begin
                        r_state <= r_ret;
                    end
                end
                S_SCALE: begin
                    tbuf[r_pos] <= mul_rsp.p[31:8];
                    r_div_req   <= '{go: 1'b1, a: (ln_y - wsce_pkg::ONE_Q32) << 32,
                                     b: ln_y + wsce_pkg::ONE_Q32};
                    r_ret   <= S_LN_Z;
                    r_state <= S_WAIT;
                end
                S_LN_Z: begin
                    r_term    <= div_rsp.q[31:0];
                    r_sum     <= '0;
                    r_n       <= 5'd1;
                    r_mul_req <= '{go: 1'b1, a: div_rsp.q[31:0], b: div_rsp.q[31:0]};
                    r_ret     <= S_LN_Z2;
                    r_state   <= S_WAIT;
                end
                S_LN_Z2: begin
                    r_z2      <= mul_rsp.p[63:32];
                    r_div_req <= '{go: 1'b1, a: 64'(r_term), b: 64'(r_n)};
                    r_ret     <= S_LN_ADD;
                    r_state   <= S_WAIT;
                end
                S_LN_ADD: begin
                    r_sum     <= r_sum + 33'(div_rsp.q[31:0]);
                    r_mul_req <= '{go: 1'b1, a: r_term, b: r_z2};
                    r_ret     <= S_LN_NEXT;
                    r_state   <= S_WAIT;
                end
                S_LN_NEXT: begin
                    r_term <= mul_rsp.p[63:32];
                    if (r_n == 5'd21) begin
                        r_mul_req <= '{go: 1'b1, a: 32'(5'd16 - lg_m),
                                       b: wsce_pkg::LN2_Q32[31:0]};
                        r_ret <= S_LN_FIN;
                    end else begin
                        r_n       <= r_n + 5'd2;
                        r_div_req <= '{go: 1'b1, a: 64'(mul_rsp.p[63:32]),
                                       b: 64'(r_n + 5'd2)};
                        r_ret     <= S_LN_ADD;
                    end
                    r_state <= S_WAIT;
                end
                S_LN_FIN: begin
                    lbuf[r_pos] <= neg_ln;
                    if (r_cl || r_sl || (r_pos == PW'(MAX_CLASSES - 1))) begin
                        r_ncls  <= NW'(r_pos) + 1'b1;
                        r_c     <= '0;
                        r_mx    <= '0;
                        r_total <= '0;
                        r_state <= S_MAX;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_MAX: begin
                    r_mx <= mx_new;
                    if (r_c == r_ncls - 1'b1) begin
                        r_c     <= '0;
                        r_state <= S_EXP_START;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_EXP_START: begin
                    r_div_req <= '{go: 1'b1, a: 64'(r_mx - tbuf[c_idx]) << 16,
                                   b: wsce_pkg::LN2_Q32};
                    r_ret   <= S_EXP_K;
                    r_state <= S_WAIT;
                end
                S_EXP_K: begin
                    // first term is the reduced argument itself
                    r_k       <= div_rsp.q[8:0];
                    r_r       <= div_rsp.r[31:0];
                    r_s       <= wsce_pkg::ONE_Q32;
                    r_n       <= 5'd1;
                    r_div_req <= '{go: 1'b1, a: div_rsp.r, b: 64'd1};
                    r_ret     <= S_EXP_A;
                    r_state   <= S_WAIT;
                end
                S_EXP_A: begin
                    r_term <= div_rsp.q[31:0];
                    r_s    <= s_next;
                    if (r_n == 5'd12) begin
                        ebuf[c_idx] <= e_val;
                        r_total     <= r_total + TOT_W'(e_val);
                        if (r_c == r_ncls - 1'b1) begin
                            r_c         <= '0;
                            r_acc       <= '0;
                            r_best_g    <= '0;
                            r_best_zero <= 1'b1;
                            r_state     <= S_G_START;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_EXP_START;
                        end
                    end else begin
                        r_n       <= r_n + 5'd1;
                        r_mul_req <= '{go: 1'b1, a: div_rsp.q[31:0], b: r_r};
                        r_ret     <= S_EXP_T;
                        r_state   <= S_WAIT;
                    end
                end
                S_EXP_T: begin
                    r_div_req <= '{go: 1'b1, a: 64'(mul_rsp.p[63:32]), b: 64'(r_n)};
                    r_ret     <= S_EXP_A;
                    r_state   <= S_WAIT;
                end
                S_G_START: begin
                    r_div_req <= '{go: 1'b1, a: 64'(ebuf[c_idx]) << 16, b: 64'(r_total)};
                    r_ret     <= S_G_Q;
                    r_state   <= S_WAIT;
                end
                S_G_Q: begin
                    // class 0 wins ties
                    if ((r_c == '0) || (g_val > r_best_g)) begin
                        r_best_g    <= g_val;
                        r_best_zero <= (r_c == '0);
                    end
                    r_mul_req <= '{go: 1'b1, a: 32'(g_val), b: 32'(lbuf[c_idx])};
                    r_ret     <= S_G_ACC;
                    r_state   <= S_WAIT;
                end
                S_G_ACC: begin
                    r_acc <= r_acc + ACC_W'(mul_rsp.p);
                    if (r_c == r_ncls - 1'b1) begin
                        r_state <= S_ACCUM;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_G_START;
                    end
                end
                S_ACCUM: begin
                    if (r_best_zero) begin
                        r_fsum <= fsum_add[48] ? wsce_pkg::SUM_MAX : fsum_add[47:0];
                        if (r_nf != '1) begin
                            r_nf <= r_nf + 1'b1;
                        end
                    end else begin
                        r_osum <= osum_add[48] ? wsce_pkg::SUM_MAX : osum_add[47:0];
                        if (r_no != '1) begin
                            r_no <= r_no + 1'b1;
                        end
                    end
                    r_pos   <= '0;
                    r_state <= r_sl ? S_RES : S_IDLE;
                end
                S_RES: begin
                    if (r_mode) begin
                        r_div_req <= '{go: 1'b1, a: 64'(r_fsum) << 16,
                                       b: (64'(r_nf) << 16) + 64'(r_eps)};
                        r_ret <= S_RQ1;
                    end else begin
                        r_div_req <= '{go: 1'b1, a: 64'(r_fsum) + 64'(r_osum),
                                       b: 64'(r_ec)};
                        r_ret <= S_RPLAIN;
                    end
                    r_state <= S_WAIT;
                end
                S_RQ1: begin
                    r_q1      <= sat32(div_rsp.q);
                    r_div_req <= '{go: 1'b1, a: 64'(r_osum) << 16,
                                   b: (64'(r_no) << 16) + 64'(r_eps)};
                    r_ret     <= S_RQ2;
                    r_state   <= S_WAIT;
                end
                S_RQ2: begin
                    r_loss  <= (loss_w[33:32] != 2'd0) ? 32'hFFFF_FFFF : loss_w[31:0];
                    r_state <= S_OUT;
                end
                S_RPLAIN: begin
                    r_loss  <= sat32(div_rsp.q);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_mv || m_axis_tready) begin
                        r_mv     <= 1'b1;
                        r_m_loss <= r_loss;
                        r_m_free <= 24'(r_nf);
                        r_m_occ  <= 24'(r_no);
                        r_m_ovf  <= ovf;
                        r_fsum   <= '0;
                        r_osum   <= '0;
                        r_nf     <= '0;
                        r_no     <= '0;
                        r_ec     <= '0;
                        r_pos    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {r_m_occ, r_m_free, r_m_loss};
    assign m_axis_tuser  = r_m_ovf;

endmodule

@@ src/wsce_check.sv @@
// Port-level checks for the loss block, bound to the top level.
module wsce_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // no result survives reset
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an accepted item keeps the block busy for the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken twice in a row");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind weighted_soft_cross_entropy_loss_top wsce_check u_wsce_check (.*);
